// ----- rtl/mpfe_pkg.sv -----
// shared types, codes and helper functions for the pwm fade engine
// no dependencies
`timescale 1ns / 1ps

package mpfe_pkg;

  localparam int DUTY_W = 16;
  localparam int TIME_W = 32;
  localparam int PROD_W = DUTY_W + TIME_W;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_FADE  = 2'd1;
  localparam logic [1:0] ACT_QUEUE = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic CFG_MAX_DUTY = 1'b0;
  localparam logic CFG_GAP      = 1'b1;

  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 16'd4095;
  localparam logic [DUTY_W-1:0] GAP_RST      = 16'd15;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_STOP,
    CMD_QUEUE,
    CMD_PEND_SEL,
    CMD_PEND_APPLY,
    CMD_CUR_ZERO,
    CMD_CUR_CH,
    CMD_CUR_INC,
    CMD_FADE_LOAD,
    CMD_FADE_MUL,
    CMD_DIV_GO,
    CMD_FADE_UPD,
    CMD_FORCE,
    CMD_START,
    CMD_EMIT,
    CMD_FLUSH
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FORCE,
    S_START,
    S_PEND_RD,
    S_PEND_APPLY,
    S_FADE_FIRST,
    S_SCAN,
    S_FADE_RD,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_UPD,
    S_NEXT,
    S_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic       ch_ok;
    logic       from_zero;
    logic       gap_ok;
    logic       pend_any;
    logic       cur_active;
    logic       cur_last;
    logic       time_done;
    logic       div_done;
    logic       chg;
    logic       hold_valid;
    logic       out_free;
  } status_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d,
                                                   input logic [DUTY_W-1:0] maxd);
    clamp_duty = (d > maxd) ? maxd : d;
  endfunction

  // final duty stored by a channel setting
  function automatic logic [DUTY_W-1:0] set_duty(input logic on,
                                                 input logic [DUTY_W-1:0] d,
                                                 input logic keep,
                                                 input logic [DUTY_W-1:0] maxd);
    logic [DUTY_W-1:0] c;
    c = clamp_duty(d, maxd);
    if (on && c == '0 && !keep) begin
      c = maxd;
    end
    set_duty = c;
  endfunction

endpackage

// ----- rtl/mpfe_div.sv -----
// restoring divider, one quotient bit per cycle
// quotient is known to fit in DUTY_W bits; uses mpfe_pkg
`timescale 1ns / 1ps

module mpfe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mpfe_pkg::PROD_W-1:0]   dividend,
  input  logic [mpfe_pkg::TIME_W-1:0]   divisor,
  output logic [mpfe_pkg::DUTY_W-1:0]   quotient,
  output logic                          done
);

  logic                          busy;
  logic [3:0]                    cnt;
  logic [mpfe_pkg::TIME_W-1:0]   rem;
  logic [mpfe_pkg::DUTY_W-1:0]   low;
  logic [mpfe_pkg::TIME_W:0]     trial;
  logic [mpfe_pkg::TIME_W:0]     diff;
  logic                          ge;

  assign trial = {rem, low[mpfe_pkg::DUTY_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[mpfe_pkg::PROD_W-1:mpfe_pkg::DUTY_W];
      low      <= dividend[mpfe_pkg::DUTY_W-1:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[mpfe_pkg::TIME_W-1:0] : trial[mpfe_pkg::TIME_W-1:0];
      low      <= {low[mpfe_pkg::DUTY_W-2:0], 1'b0};
      quotient <= {quotient[mpfe_pkg::DUTY_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/mpfe_dp.sv -----
// datapath: channel state, fade and pending stores, divider, result registers
// uses mpfe_pkg and mpfe_div
`timescale 1ns / 1ps

module mpfe_dp #(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mpfe_pkg::cmd_t        cmd,
  output mpfe_pkg::status_t     st,
  input  logic [1:0]            action,
  input  logic [31:0]           now_ms,
  input  logic [3:0]            channel,
  input  logic [15:0]           level,
  input  logic [31:0]           fade_len_ms,
  input  logic                  turn_on,
  input  logic                  keep_zero,
  input  logic                  fade_from_zero,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_channel,
  output logic [15:0]           out_duty,
  output logic                  out_on,
  output logic                  last
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW = mpfe_pkg::DUTY_W;
  localparam int TW = mpfe_pkg::TIME_W;

  typedef struct packed {
    logic [TW-1:0] start;
    logic [TW-1:0] len;
    logic [DW-1:0] from;
    logic [DW-1:0] to;
  } fade_t;

  // latched item
  logic [1:0]    i_action;
  logic [TW-1:0] i_now;
  logic [3:0]    i_channel;
  logic [DW-1:0] i_level;
  logic [TW-1:0] i_dur;
  logic          i_turn_on;
  logic          i_keep_zero;
  logic          i_from_zero;

  logic [DW-1:0] max_duty;
  logic [DW-1:0] gap_ms;
  logic [TW-1:0] last_apply;

  logic [CHANNELS-1:0] chan_on;
  logic [DW-1:0]       chan_duty [CHANNELS];
  logic [CHANNELS-1:0] fade_active;
  logic [CHANNELS-1:0] pend_valid;

  fade_t         fade_mem [CHANNELS];
  logic [17:0]   pend_mem [CHANNELS];
  fade_t         fade_rd;
  logic [17:0]   pend_rd;

  logic [CW-1:0] cur;
  logic [CW-1:0] pend_idx;
  logic [CW-1:0] ch_idx;
  logic          chg;

  logic [TW-1:0]                 f_elapsed;
  logic [TW-1:0]                 f_len;
  logic [DW-1:0]                 f_from;
  logic [DW-1:0]                 f_to;
  logic                          time_done;
  logic [mpfe_pkg::PROD_W-1:0]   prod;
  logic [DW-1:0]                 f_diff;
  logic [DW-1:0]                 quo;
  logic                          div_done;

  logic          hold_valid;
  logic [3:0]    hold_channel;
  logic [DW-1:0] hold_duty;
  logic          hold_on;
  logic          out_free;
  logic          push;

  logic          cur_on;
  logic [DW-1:0] cur_duty;
  logic [DW-1:0] upd_raw;
  logic          upd_on;
  logic [DW-1:0] upd_duty;
  logic [DW-1:0] pa_duty;
  logic [TW-1:0] ld_elapsed;

  assign ch_idx   = CW'(i_channel);
  assign cur_on   = chan_on[cur];
  assign cur_duty = chan_duty[cur];
  assign out_free = !out_valid || out_ready;
  assign f_diff   = (f_to >= f_from) ? (f_to - f_from) : (f_from - f_to);
  assign push     = (cmd == mpfe_pkg::CMD_EMIT && hold_valid) || cmd == mpfe_pkg::CMD_FLUSH;

  always_comb begin
    pend_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pend_valid[i]) begin
        pend_idx = CW'(i);
      end
    end
  end

  assign ld_elapsed    = i_now - fade_rd.start;
  assign upd_raw = time_done ? f_to : ((f_to >= f_from) ? (f_from + quo) : (f_from - quo));
  assign upd_on  = (upd_raw != '0) || (f_to != '0);
  assign upd_duty = mpfe_pkg::set_duty(upd_on, upd_raw, 1'b1, max_duty);
  assign pa_duty  = mpfe_pkg::set_duty(pend_rd[16], pend_rd[15:0], pend_rd[17], max_duty);

  always_comb begin
    st.action     = i_action;
    st.ch_ok      = {28'd0, i_channel} < 32'(CHANNELS);
    st.from_zero  = i_from_zero;
    st.gap_ok     = (last_apply == '0) || ((i_now - last_apply) >= {16'd0, gap_ms});
    st.pend_any   = |pend_valid;
    st.cur_active = fade_active[cur];
    st.cur_last   = cur == CW'(CHANNELS - 1);
    st.time_done  = time_done;
    st.div_done   = div_done;
    st.chg        = chg;
    st.hold_valid = hold_valid;
    st.out_free   = out_free;
  end

  mpfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd == mpfe_pkg::CMD_DIV_GO),
    .dividend (prod),
    .divisor  (f_len),
    .quotient (quo),
    .done     (div_done)
  );

  // item latch and fade operands
  always_ff @(posedge clk) begin
    if (cmd == mpfe_pkg::CMD_LATCH) begin
      i_action    <= action;
      i_now       <= now_ms;
      i_channel   <= channel;
      i_level     <= level;
      i_dur       <= fade_len_ms;
      i_turn_on   <= turn_on;
      i_keep_zero <= keep_zero;
      i_from_zero <= fade_from_zero;
    end
    if (cmd == mpfe_pkg::CMD_FADE_LOAD) begin
      f_elapsed <= ld_elapsed;
      f_len     <= fade_rd.len;
      f_from    <= fade_rd.from;
      f_to      <= fade_rd.to;
      time_done <= ld_elapsed >= fade_rd.len;
    end
    if (cmd == mpfe_pkg::CMD_FADE_MUL) begin
      prod <= f_diff * f_elapsed;
    end
  end

  // stores without reset
  always_ff @(posedge clk) begin
    fade_rd <= fade_mem[cur];
    pend_rd <= pend_mem[cur];
    if (cmd == mpfe_pkg::CMD_START) begin
      fade_mem[cur] <= '{start: i_now,
                         len:   (i_dur == '0) ? 32'd1 : i_dur,
                         from:  cur_on ? cur_duty : '0,
                         to:    mpfe_pkg::clamp_duty(i_level, max_duty)};
    end
    if (cmd == mpfe_pkg::CMD_QUEUE) begin
      pend_mem[ch_idx] <= {i_keep_zero, i_turn_on,
                           mpfe_pkg::clamp_duty(i_level, max_duty)};
    end
  end

  // control state of the channels
  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty    <= mpfe_pkg::MAX_DUTY_RST;
      gap_ms      <= mpfe_pkg::GAP_RST;
      last_apply  <= '0;
      chan_on     <= '0;
      fade_active <= '0;
      pend_valid  <= '0;
      cur         <= '0;
      chg         <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_duty[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == mpfe_pkg::CFG_MAX_DUTY) begin
          max_duty <= cfg_data;
        end else begin
          gap_ms <= cfg_data;
        end
      end
      case (cmd)
        mpfe_pkg::CMD_STOP: begin
          fade_active <= '0;
          pend_valid  <= '0;
        end
        mpfe_pkg::CMD_QUEUE: begin
          pend_valid[ch_idx] <= 1'b1;
        end
        mpfe_pkg::CMD_PEND_SEL: begin
          cur <= pend_idx;
        end
        mpfe_pkg::CMD_PEND_APPLY: begin
          pend_valid[cur] <= 1'b0;
          last_apply      <= i_now;
          chg             <= (cur_on != pend_rd[16]) || (cur_duty != pa_duty);
          chan_on[cur]    <= pend_rd[16];
          chan_duty[cur]  <= pa_duty;
        end
        mpfe_pkg::CMD_CUR_ZERO: begin
          cur <= '0;
        end
        mpfe_pkg::CMD_CUR_CH: begin
          cur <= ch_idx;
        end
        mpfe_pkg::CMD_CUR_INC: begin
          cur <= cur + CW'(1);
        end
        mpfe_pkg::CMD_FADE_UPD: begin
          chg            <= (cur_on != upd_on) || (cur_duty != upd_duty);
          chan_on[cur]   <= upd_on;
          chan_duty[cur] <= upd_duty;
          if (time_done) begin
            fade_active[cur] <= 1'b0;
          end
        end
        mpfe_pkg::CMD_FORCE: begin
          chg            <= !cur_on || (cur_duty != '0);
          chan_on[cur]   <= 1'b1;
          chan_duty[cur] <= '0;
        end
        mpfe_pkg::CMD_START: begin
          chg              <= 1'b1;
          fade_active[cur] <= 1'b1;
          chan_on[cur]     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // one result held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd == mpfe_pkg::CMD_EMIT) begin
        hold_valid <= 1'b1;
      end else if (cmd == mpfe_pkg::CMD_FLUSH) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == mpfe_pkg::CMD_EMIT) begin
      hold_channel <= 4'(cur);
      hold_duty    <= cur_on ? cur_duty : '0;
      hold_on      <= cur_on;
    end
    if (push) begin
      out_channel <= hold_channel;
      out_duty    <= hold_duty;
      out_on      <= hold_on;
      last        <= cmd == mpfe_pkg::CMD_FLUSH;
    end
  end

endmodule

// ----- rtl/mpfe_ctrl.sv -----
// controller state machine: sequences one item through the datapath
// uses mpfe_pkg
`timescale 1ns / 1ps

module mpfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output mpfe_pkg::cmd_t     cmd,
  input  mpfe_pkg::status_t  st
);

  mpfe_pkg::state_t state, state_next;
  mpfe_pkg::state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpfe_pkg::S_IDLE;
      ret   <= mpfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = mpfe_pkg::CMD_NOP;
    in_ready   = 1'b0;
    case (state)
      mpfe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = mpfe_pkg::CMD_LATCH;
          state_next = mpfe_pkg::S_DISPATCH;
        end
      end
      mpfe_pkg::S_DISPATCH: begin
        case (st.action)
          mpfe_pkg::ACT_TICK: begin
            if (st.gap_ok && st.pend_any) begin
              cmd        = mpfe_pkg::CMD_PEND_SEL;
              state_next = mpfe_pkg::S_PEND_RD;
            end else begin
              cmd        = mpfe_pkg::CMD_CUR_ZERO;
              state_next = mpfe_pkg::S_SCAN;
            end
          end
          mpfe_pkg::ACT_FADE: begin
            if (st.ch_ok) begin
              cmd        = mpfe_pkg::CMD_CUR_CH;
              state_next = st.from_zero ? mpfe_pkg::S_FORCE : mpfe_pkg::S_START;
            end else begin
              state_next = mpfe_pkg::S_FINISH;
            end
          end
          mpfe_pkg::ACT_QUEUE: begin
            if (st.ch_ok) begin
              cmd = mpfe_pkg::CMD_QUEUE;
            end
            state_next = mpfe_pkg::S_FINISH;
          end
          default: begin
            cmd        = mpfe_pkg::CMD_STOP;
            state_next = mpfe_pkg::S_FINISH;
          end
        endcase
      end
      mpfe_pkg::S_FORCE: begin
        cmd        = mpfe_pkg::CMD_FORCE;
        state_next = mpfe_pkg::S_EMIT;
        ret_next   = mpfe_pkg::S_START;
      end
      mpfe_pkg::S_START: begin
        cmd        = mpfe_pkg::CMD_START;
        state_next = mpfe_pkg::S_EMIT;
        ret_next   = mpfe_pkg::S_FINISH;
      end
      mpfe_pkg::S_PEND_RD: begin
        state_next = mpfe_pkg::S_PEND_APPLY;
      end
      mpfe_pkg::S_PEND_APPLY: begin
        cmd        = mpfe_pkg::CMD_PEND_APPLY;
        state_next = mpfe_pkg::S_EMIT;
        ret_next   = mpfe_pkg::S_FADE_FIRST;
      end
      mpfe_pkg::S_FADE_FIRST: begin
        cmd        = mpfe_pkg::CMD_CUR_ZERO;
        state_next = mpfe_pkg::S_SCAN;
      end
      mpfe_pkg::S_SCAN: begin
        // store read data for cur is ready in the next cycle
        if (st.cur_active) begin
          state_next = mpfe_pkg::S_FADE_RD;
        end else if (st.cur_last) begin
          state_next = mpfe_pkg::S_FINISH;
        end else begin
          cmd = mpfe_pkg::CMD_CUR_INC;
        end
      end
      mpfe_pkg::S_FADE_RD: begin
        cmd        = mpfe_pkg::CMD_FADE_LOAD;
        state_next = mpfe_pkg::S_MUL;
      end
      mpfe_pkg::S_MUL: begin
        cmd        = mpfe_pkg::CMD_FADE_MUL;
        state_next = st.time_done ? mpfe_pkg::S_UPD : mpfe_pkg::S_DIV_GO;
      end
      mpfe_pkg::S_DIV_GO: begin
        cmd        = mpfe_pkg::CMD_DIV_GO;
        state_next = mpfe_pkg::S_DIV_WAIT;
      end
      mpfe_pkg::S_DIV_WAIT: begin
        if (st.div_done) begin
          state_next = mpfe_pkg::S_UPD;
        end
      end
      mpfe_pkg::S_UPD: begin
        cmd        = mpfe_pkg::CMD_FADE_UPD;
        state_next = mpfe_pkg::S_EMIT;
        ret_next   = mpfe_pkg::S_NEXT;
      end
      mpfe_pkg::S_NEXT: begin
        if (st.cur_last) begin
          state_next = mpfe_pkg::S_FINISH;
        end else begin
          cmd        = mpfe_pkg::CMD_CUR_INC;
          state_next = mpfe_pkg::S_SCAN;
        end
      end
      mpfe_pkg::S_EMIT: begin
        if (!st.chg) begin
          state_next = ret;
        end else if (!st.hold_valid || st.out_free) begin
          cmd        = mpfe_pkg::CMD_EMIT;
          state_next = ret;
        end
      end
      mpfe_pkg::S_FINISH: begin
        if (!st.hold_valid) begin
          state_next = mpfe_pkg::S_IDLE;
        end else if (st.out_free) begin
          cmd        = mpfe_pkg::CMD_FLUSH;
          state_next = mpfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mpfe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/multichannel_pwm_fade_engine_core.sv -----
// multichannel pwm fade engine, one item at a time
// queue and stop go straight to the finish state; a start fade may first force the channel
// to zero; a tick applies at most one pending target, then scans every channel and uses
// the shared divider for each fade that has not reached its end; results wait in a hold
// register until the next push; the next item is taken while the final result still waits in the output register
// synchronous reset clears channel state, valid bits and registers to their reset values
`timescale 1ns / 1ps

module multichannel_pwm_fade_engine_core #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [3:0]  channel,
  input  logic [15:0] level,
  input  logic [31:0] fade_len_ms,
  input  logic        turn_on,
  input  logic        keep_zero,
  input  logic        fade_from_zero,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel,
  output logic [15:0] out_duty,
  output logic        out_on,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  mpfe_pkg::cmd_t    cmd;
  mpfe_pkg::status_t st;

  mpfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  mpfe_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .action         (action),
    .now_ms         (now_ms),
    .channel        (channel),
    .level          (level),
    .fade_len_ms    (fade_len_ms),
    .turn_on        (turn_on),
    .keep_zero      (keep_zero),
    .fade_from_zero (fade_from_zero),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_duty       (out_duty),
    .out_on         (out_on),
    .last           (last)
  );

  // nothing held back while waiting for an item
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !st.hold_valid)
    else $error("held result left over between items");

  a_emit_changed: assert property (@(posedge clk) disable iff (rst)
    cmd == mpfe_pkg::CMD_EMIT |-> st.chg)
    else $error("write issued for an unchanged channel");

  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    cmd == mpfe_pkg::CMD_FLUSH |-> st.out_free)
    else $error("final result pushed over a waiting one");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    cmd == mpfe_pkg::CMD_STOP |=> !st.pend_any)
    else $error("pending targets survive stop");

endmodule

// ----- test/multichannel_pwm_fade_engine_core_tb.sv -----
// testbench for the multichannel pwm fade engine core
// self-checking: a behavioral fade predictor fills a queue of expected pin writes
// depends on rtl/mpfe_pkg.sv and rtl/multichannel_pwm_fade_engine_core.sv
`timescale 1ns / 1ps

module multichannel_pwm_fade_engine_core_tb;

  localparam int NCH = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  ch;
    logic [15:0] duty;
    logic        on;
    logic        lst;
  } pin_write_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic [3:0]  channel;
  logic [15:0] level;
  logic [31:0] fade_len_ms;
  logic        turn_on;
  logic        keep_zero;
  logic        fade_from_zero;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_channel;
  logic [15:0] out_duty;
  logic        out_on;
  logic        last;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  multichannel_pwm_fade_engine_core #(.CHANNELS(NCH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .now_ms(now_ms), .channel(channel), .level(level),
    .fade_len_ms(fade_len_ms), .turn_on(turn_on), .keep_zero(keep_zero),
    .fade_from_zero(fade_from_zero),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_channel(out_channel), .out_duty(out_duty), .out_on(out_on), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predictor state
  logic [15:0] pm_max_duty;
  logic [15:0] pm_gap;
  logic        pm_on      [NCH];
  logic [15:0] pm_duty    [NCH];
  logic        pm_fading  [NCH];
  logic [31:0] pm_fstart  [NCH];
  logic [31:0] pm_flen    [NCH];
  logic [15:0] pm_ffrom   [NCH];
  logic [15:0] pm_fto     [NCH];
  logic        pm_pend    [NCH];
  logic [17:0] pm_ptarget [NCH];
  logic [31:0] pm_last_apply;

  pin_write_t expected_writes[$];
  pin_write_t item_writes[$];

  int errors;
  int writes_seen;
  int items_sent;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  logic [31:0] clock_ms;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (write %0d)", what, got, want, writes_seen);
  endtask

  function automatic logic [15:0] limit_duty(input logic [15:0] d);
    return (d > pm_max_duty) ? pm_max_duty : d;
  endfunction

  function automatic void note_write(input int ch);
    pin_write_t w;
    w.ch = ch[3:0];
    w.on = pm_on[ch];
    w.duty = pm_on[ch] ? pm_duty[ch] : 16'd0;
    w.lst = 1'b0;
    item_writes.push_back(w);
  endfunction

  function automatic bit apply_setting(input int ch, input logic on, input logic [15:0] d,
                                       input logic keep);
    logic [15:0] v;
    bit chg;
    v = limit_duty(d);
    if (on && v == 16'd0 && !keep) v = pm_max_duty;
    chg = (pm_on[ch] != on) || (pm_duty[ch] != v);
    pm_on[ch] = on;
    pm_duty[ch] = v;
    return chg;
  endfunction

  function automatic void advance_fade(input int ch, input logic [31:0] now);
    logic [31:0] el;
    logic [31:0] len;
    logic [15:0] d;
    logic [63:0] prod;
    if (!pm_fading[ch]) return;
    el = now - pm_fstart[ch];
    len = (pm_flen[ch] == 0) ? 32'd1 : pm_flen[ch];
    d = pm_fto[ch];
    if (el < len) begin
      if (pm_fto[ch] >= pm_ffrom[ch]) begin
        prod = 64'(pm_fto[ch] - pm_ffrom[ch]) * 64'(el);
        d = pm_ffrom[ch] + 16'(prod / 64'(len));
      end else begin
        prod = 64'(pm_ffrom[ch] - pm_fto[ch]) * 64'(el);
        d = pm_ffrom[ch] - 16'(prod / 64'(len));
      end
    end else begin
      pm_fading[ch] = 1'b0;
    end
    if (apply_setting(ch, (d != 0) || (pm_fto[ch] != 0), d, 1'b1)) note_write(ch);
  endfunction

  function automatic void predict_writes(input logic [1:0] act, input logic [31:0] now,
                                         input logic [3:0] ch, input logic [15:0] lvl,
                                         input logic [31:0] dur, input logic ton,
                                         input logic kz, input logic fz);
    pin_write_t w;
    logic [17:0] t;
    item_writes.delete();
    case (act)
      mpfe_pkg::ACT_TICK: begin
        if (pm_last_apply == 0 || (now - pm_last_apply) >= 32'(pm_gap)) begin
          for (int i = 0; i < NCH; i++) begin
            if (pm_pend[i]) begin
              t = pm_ptarget[i];
              pm_pend[i] = 1'b0;
              pm_last_apply = now;
              if (apply_setting(i, t[16], t[15:0], t[17])) note_write(i);
              break;
            end
          end
        end
        for (int i = 0; i < NCH; i++) advance_fade(i, now);
      end
      mpfe_pkg::ACT_FADE: begin
        if (fz && apply_setting(int'(ch), 1'b1, 16'd0, 1'b1)) note_write(int'(ch));
        pm_fading[ch] = 1'b1;
        pm_fstart[ch] = now;
        pm_flen[ch] = (dur == 0) ? 32'd1 : dur;
        pm_ffrom[ch] = pm_on[ch] ? pm_duty[ch] : 16'd0;
        pm_fto[ch] = limit_duty(lvl);
        pm_on[ch] = 1'b1;
        note_write(int'(ch));
      end
      mpfe_pkg::ACT_QUEUE: begin
        pm_pend[ch] = 1'b1;
        pm_ptarget[ch] = {kz, ton, limit_duty(lvl)};
      end
      default: begin
        for (int i = 0; i < NCH; i++) begin
          pm_fading[i] = 1'b0;
          pm_pend[i] = 1'b0;
        end
      end
    endcase
    if (item_writes.size() > 0) begin
      w = item_writes.pop_back();
      w.lst = 1'b1;
      item_writes.push_back(w);
    end
    foreach (item_writes[k]) expected_writes.push_back(item_writes[k]);
  endfunction

  // called at a falling edge; returns at the falling edge after the accepting edge
  // with valid still high, so the next item can follow with no gap
  task automatic send_item(input logic [1:0] act, input logic [31:0] now,
                           input logic [3:0] ch, input logic [15:0] lvl,
                           input logic [31:0] dur, input logic ton, input logic kz,
                           input logic fz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action <= act;
    now_ms <= now;
    channel <= ch;
    level <= lvl;
    fade_len_ms <= dur;
    turn_on <= ton;
    keep_zero <= kz;
    fade_from_zero <= fz;
    predict_writes(act, now, ch, lvl, dur, ton, kz, fz);
    // ready only moves at rising edges, so its value here holds for the next edge
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == mpfe_pkg::CFG_MAX_DUTY) pm_max_duty = val;
    else pm_gap = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // time moves forward, mostly by one millisecond
  function automatic logic [31:0] next_ms();
    clock_ms += ($urandom_range(9) == 0) ? $urandom_range(40) : 1;
    return clock_ms;
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      send_item(mpfe_pkg::ACT_TICK, next_ms(), 4'($urandom), 16'($urandom), $urandom,
                1'($urandom), 1'($urandom), 1'($urandom));
    else if (r < 72)
      send_item(mpfe_pkg::ACT_FADE, clock_ms, 4'($urandom),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(pm_max_duty)),
                ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(60)),
                1'($urandom), 1'($urandom), 1'($urandom));
    else if (r < 96)
      send_item(mpfe_pkg::ACT_QUEUE, clock_ms, 4'($urandom),
                ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom), $urandom, 1'($urandom),
                1'($urandom), 1'($urandom));
    else
      send_item(mpfe_pkg::ACT_STOP, clock_ms, 4'($urandom), 16'($urandom), $urandom,
                1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_edges();
    clock_ms = 32'd0;
    // tick at time zero with nothing pending or fading
    send_item(mpfe_pkg::ACT_TICK, 32'd0, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    // queued on at zero: becomes max unless keep_zero
    send_item(mpfe_pkg::ACT_QUEUE, 32'd0, 4'd3, 16'd0, 32'd0, 1'b1, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_QUEUE, 32'd0, 4'd15, 16'hFFFF, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(mpfe_pkg::ACT_QUEUE, 32'd0, 4'd7, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_item(mpfe_pkg::ACT_TICK, 32'd5, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'd10, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'd20, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'd40, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    // fades: zero length, from zero, huge length, clamped level
    send_item(mpfe_pkg::ACT_FADE, 32'd40, 4'd0, 16'd1000, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_FADE, 32'd40, 4'd15, 16'd0, 32'd10, 1'b0, 1'b0, 1'b1);
    send_item(mpfe_pkg::ACT_FADE, 32'd40, 4'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_item(mpfe_pkg::ACT_FADE, 32'd40, 4'd9, 16'd200, 32'd8, 1'b0, 1'b0, 1'b1);
    send_item(mpfe_pkg::ACT_TICK, 32'd41, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'd45, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'd60, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_QUEUE, 32'd60, 4'd3, 16'd10, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_STOP, 32'hFFFF_FFFF, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    // wrapping time
    send_item(mpfe_pkg::ACT_FADE, 32'hFFFF_FFF0, 4'd5, 16'd300, 32'd40, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'h0000_0010, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(mpfe_pkg::ACT_TICK, 32'h0000_0040, 4'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    clock_ms = 32'h40;
  endtask

  task automatic test_register_extremes();
    write_reg(mpfe_pkg::CFG_MAX_DUTY, 16'hFFFF);
    write_reg(mpfe_pkg::CFG_GAP, 16'd0);
    repeat (20) random_item();
    write_reg(mpfe_pkg::CFG_MAX_DUTY, 16'd1);
    write_reg(mpfe_pkg::CFG_GAP, 16'hFFFF);
    repeat (20) random_item();
    write_reg(mpfe_pkg::CFG_MAX_DUTY, 16'd255);
    write_reg(mpfe_pkg::CFG_GAP, 16'd3);
  endtask

  task automatic test_random_phases();
    int sp [4] = '{0, 67, 0, 9};
    int rp [4] = '{0, 0, 67, 9};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sp[p];
      recv_stall_pct = rp[p];
      repeat (70) random_item();
      if (p == 1) wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (30) random_item();
  endtask

  // result checker
  always @(posedge clk) begin
    pin_write_t w;
    if (!rst && out_valid && out_ready) begin
      writes_seen++;
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected write", {28'd0, out_channel}, 32'd0);
      end else begin
        w = expected_writes.pop_front();
        if (out_channel !== w.ch) report_mismatch("out_channel", 32'(out_channel), 32'(w.ch));
        if (out_duty !== w.duty) report_mismatch("out_duty", 32'(out_duty), 32'(w.duty));
        if (out_on !== w.on) report_mismatch("out_on", 32'(out_on), 32'(w.on));
        if (last !== w.lst) report_mismatch("last", 32'(last), 32'(w.lst));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    writes_seen = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = mpfe_pkg::ACT_TICK;
    now_ms = '0;
    channel = '0;
    level = '0;
    fade_len_ms = '0;
    turn_on = 1'b0;
    keep_zero = 1'b0;
    fade_from_zero = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mpfe_pkg::CFG_MAX_DUTY;
    cfg_data = '0;
    out_ready = 1'b1;
    pm_max_duty = mpfe_pkg::MAX_DUTY_RST;
    pm_gap = mpfe_pkg::GAP_RST;
    pm_last_apply = '0;
    for (int i = 0; i < NCH; i++) begin
      pm_on[i] = 1'b0;
      pm_duty[i] = '0;
      pm_fading[i] = 1'b0;
      pm_pend[i] = 1'b0;
      pm_fstart[i] = '0;
      pm_flen[i] = '0;
      pm_ffrom[i] = '0;
      pm_fto[i] = '0;
      pm_ptarget[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_edges();
    test_register_extremes();
    test_random_phases();
    wait_drained();
    $display("covered %0d items and %0d pin writes across idle/stall phases", items_sent,
             writes_seen);
    $display("registers swept to extremes; fades, queued targets, stops and wrap exercised");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
